/* hw/rtl/track_buffer_cache_manager_core_assert.svh */
// Assertion macros for the track buffer cache manager.
`ifndef TRACK_BUFFER_CACHE_MANAGER_CORE_ASSERT_SVH
`define TRACK_BUFFER_CACHE_MANAGER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TBCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define TBCM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden state");
`else
`define TBCM_ASSERT(lbl, prop)
`define TBCM_NEVER(lbl, cond)
`endif
`endif

/* hw/rtl/tbcm_pkg.sv */
// Shared types, constants and helpers of the track buffer cache manager.
package tbcm_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int MAX_WB      = 32;
  localparam int REFS_MAX    = 63;
  localparam int SPT_RESET   = 18;
  localparam int SPT_MAX     = 64;

  localparam int OPC_W  = 2;
  localparam int DEV_W  = 8;
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 5;
  localparam int OFF_W  = 6;
  localparam int REFS_W = 6;
  localparam int SPT_W  = 7;
  localparam int KIND_W = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_ACQ   = 2'd0,
    OP_REL   = 2'd1,
    OP_SYNC  = 2'd2,
    OP_PURGE = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    K_ACQ  = 3'd0,
    K_REL  = 3'd1,
    K_WB   = 3'd2,
    K_RD   = 3'd3,
    K_BUSY = 3'd4,
    K_BAD  = 3'd5,
    K_DONE = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [DEV_W-1:0]   device_out;
    logic [ADDR_W-1:0]  track_address;
    logic [OFF_W-1:0]   sector_offset;
    logic               last;
  } rsp_t;

  function automatic rsp_t mk_rsp(kind_t k, logic [SLOT_W-1:0] s, logic [DEV_W-1:0] d,
                                  logic [ADDR_W-1:0] t, logic [OFF_W-1:0] o, logic l);
    rsp_t r;
    r.kind          = k;
    r.slot          = s;
    r.device_out    = d;
    r.track_address = t;
    r.sector_offset = o;
    r.last          = l;
    return r;
  endfunction

endpackage

/* hw/rtl/tbcm_req_if.sv */
// Request channel of the track buffer cache manager.
interface tbcm_req_if import tbcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [DEV_W-1:0]  device_id;
  logic [ADDR_W-1:0] sector_address;
  logic              need_contents;
  logic [SLOT_W-1:0] entry_index;
  logic              modified;
  logic              immediate;

  modport source (output valid, opcode, device_id, sector_address, need_contents,
                  entry_index, modified, immediate, input ready);
  modport sink (input valid, opcode, device_id, sector_address, need_contents,
                entry_index, modified, immediate, output ready);
endinterface

/* hw/rtl/tbcm_rsp_if.sv */
// Result channel of the track buffer cache manager.
interface tbcm_rsp_if import tbcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [DEV_W-1:0]  device_out;
  logic [ADDR_W-1:0] track_address;
  logic [OFF_W-1:0]  sector_offset;
  logic              last;

  modport source (output valid, kind, slot, device_out, track_address, sector_offset, last,
                  input ready);
  modport sink (input valid, kind, slot, device_out, track_address, sector_offset, last,
                output ready);
endinterface

/* hw/rtl/tbcm_ram.sv */
// Generic simple dual-port RAM with registered read data.
module tbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/track_buffer_cache_manager_core.sv */
// Track buffer cache tag manager with tag and status memories.
// Acquire: 8 remainder steps find the sector's offset in its track, then a tag scan and,
// unless the result is busy, a recency pass over the status memory, then its results.
// Release reads and checks its entry; sync and purge check each entry, writing back dirty ones.
// One request at a time. Synchronous reset empties the cache and sets 18 sectors per track.
`include "track_buffer_cache_manager_core_assert.svh"
module track_buffer_cache_manager_core import tbcm_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [SPT_W-1:0] wr_data,
  tbcm_req_if.sink         req,
  tbcm_rsp_if.source       rsp
);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TAG_W = DEV_W + ADDR_W;

  typedef struct packed {
    logic              valid;
    logic [REFS_W-1:0] refs;
    logic              dirty;
    logic              imm;
    logic              stale;
    logic [IDX_W-1:0]  rank;
  } meta_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_TRK, S_SCAN, S_DECIDE, S_RANK, S_BUSY, S_EMIT_WB, S_EMIT_RD,
    S_EMIT_ACQ, S_REL_RD, S_REL_CHK, S_REL_WB, S_REL_OUT, S_BAD, S_SW_RD, S_SW_CHK,
    S_SW_WB, S_DONE
  } state_t;

  state_t state;

  logic [SPT_W-1:0]  spt;
  logic [SPT_W-1:0]  spt_eff;
  opcode_t           op;
  logic [DEV_W-1:0]  dev;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] trk;
  logic              need;
  logic [SLOT_W-1:0] eidx;
  logic              mod_in;
  logic              imm_in;
  logic [ADDR_W-1:0] dsh;
  logic [OFF_W-1:0]  rem;
  logic [OFF_W-1:0]  rem_next;
  logic [2:0]        dcnt;
  logic [CNT_W-1:0]  scnt;
  logic              pv;
  logic [5:0]        wbn;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [REFS_W-1:0] hit_refs;
  logic [IDX_W-1:0]  hit_rank;
  logic              hit_stale;
  logic              vic_found;
  logic [IDX_W-1:0]  vic_idx;
  logic [IDX_W-1:0]  vic_rank;
  logic              vic_wb;
  logic [DEV_W-1:0]  cap_dev;
  logic [ADDR_W-1:0] cap_trk;
  logic [IDX_W-1:0]  e;
  logic [IDX_W-1:0]  r;
  logic              miss;
  logic              wb_flag;
  logic              rd_flag;
  logic [SLOT_W-1:0] busy_slot;
  rsp_t              o_q;
  logic              o_valid;
  logic              o_load;
  logic              out_free;
  logic [ENTRIES-1:0] init_q;

  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  raddr_q;
  logic              rd_issue;
  logic              m_we;
  meta_t             m_wdata;
  logic [$bits(meta_t)-1:0] m_rdata;
  meta_t             m;
  logic              t_we;
  logic [TAG_W-1:0]  t_rdata;
  logic [DEV_W-1:0]  t_dev;
  logic [ADDR_W-1:0] t_trk;
  logic              rel_ok;
  logic              sw_visit;
  logic              sw_stop;

  tbcm_ram #(.WIDTH($bits(meta_t)), .DEPTH(ENTRIES)) u_meta (
    .clk(clk), .we(m_we), .waddr(raddr_q), .wdata(m_wdata), .raddr(raddr), .rdata(m_rdata)
  );

  tbcm_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag (
    .clk(clk), .we(t_we), .waddr(vic_idx), .wdata({dev, trk}), .raddr(raddr), .rdata(t_rdata)
  );

  assign t_dev = t_rdata[TAG_W-1:ADDR_W];
  assign t_trk = t_rdata[ADDR_W-1:0];

  // Entries never written read as their reset contents.
  always_comb begin
    if (init_q[raddr_q]) begin
      m = meta_t'(m_rdata);
    end else begin
      m       = '0;
      m.rank  = raddr_q;
    end
  end

  always_comb begin
    if (spt == '0) begin
      spt_eff = SPT_W'(1);
    end else if (spt > SPT_W'(SPT_MAX)) begin
      spt_eff = SPT_W'(SPT_MAX);
    end else begin
      spt_eff = spt;
    end
  end

  always_comb begin
    logic [SPT_W-1:0] t;
    rem_next = rem;
    for (int k = 0; k < 4; k++) begin
      t = {rem_next, dsh[ADDR_W-1-k]};
      if (t >= spt_eff) begin
        t = t - spt_eff;
      end
      rem_next = t[OFF_W-1:0];
    end
  end

  assign rel_ok   = m.valid && (m.refs != '0);
  assign sw_visit = m.valid && ((op == OP_PURGE) ? (t_dev == dev) : m.dirty);
  assign sw_stop  = sw_visit && m.dirty && (wbn >= 6'(MAX_WB));

  always_comb begin
    raddr    = scnt[IDX_W-1:0];
    rd_issue = 1'b0;
    m_we     = 1'b0;
    m_wdata  = m;
    t_we     = 1'b0;
    unique case (state)
      S_SCAN, S_RANK: begin
        rd_issue = (scnt < CNT_W'(ENTRIES));
      end
      S_REL_RD: begin
        raddr = IDX_W'(eidx);
      end
      default: begin
      end
    endcase
    unique case (state)
      S_RANK: begin
        m_we = pv;
        if (raddr_q == e) begin
          if (miss) begin
            m_wdata.valid = 1'b1;
            m_wdata.dirty = 1'b0;
            m_wdata.imm   = 1'b0;
            m_wdata.stale = 1'b1;
          end
          if (rd_flag) begin
            m_wdata.stale = 1'b0;
          end
          m_wdata.refs = m.refs + 1'b1;
          m_wdata.rank = '0;
        end else if (m.rank < r) begin
          m_wdata.rank = m.rank + 1'b1;
        end
      end
      S_REL_CHK: begin
        m_we           = rel_ok;
        m_wdata.refs   = m.refs - 1'b1;
        m_wdata.dirty  = m.dirty | mod_in;
        m_wdata.imm    = m.imm | imm_in;
        if (m.imm | imm_in) begin
          m_wdata.dirty = 1'b0;
          m_wdata.imm   = 1'b0;
        end
      end
      S_SW_CHK: begin
        m_we          = sw_visit && !sw_stop;
        m_wdata.dirty = 1'b0;
        m_wdata.imm   = 1'b0;
        if (op == OP_PURGE) begin
          if (m.refs == '0) begin
            m_wdata.valid = 1'b0;
            m_wdata.stale = 1'b0;
          end else begin
            m_wdata.stale = 1'b1;
          end
        end
      end
      S_DECIDE: begin
        t_we = !hit_found && vic_found;
      end
      default: begin
      end
    endcase
  end

  assign out_free  = !o_valid || rsp.ready;
  assign o_load    = out_free && (state == S_BUSY || state == S_EMIT_WB || state == S_EMIT_RD ||
                     state == S_EMIT_ACQ || state == S_REL_WB || state == S_REL_OUT ||
                     state == S_BAD || state == S_SW_WB || state == S_DONE);
  assign req.ready = (state == S_IDLE);

  assign rsp.valid         = o_valid;
  assign rsp.kind          = o_q.kind;
  assign rsp.slot          = o_q.slot;
  assign rsp.device_out    = o_q.device_out;
  assign rsp.track_address = o_q.track_address;
  assign rsp.sector_offset = o_q.sector_offset;
  assign rsp.last          = o_q.last;

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (rst) begin
      state   <= S_IDLE;
      spt     <= SPT_W'(SPT_RESET);
      o_valid <= 1'b0;
      init_q  <= '0;
      pv      <= 1'b0;
    end else begin
      pv <= rd_issue;
      if (wr_en) begin
        spt <= wr_data;
      end
      if (m_we) begin
        init_q[raddr_q] <= 1'b1;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op        <= opcode_t'(req.opcode);
            dev       <= req.device_id;
            addr      <= req.sector_address;
            dsh       <= req.sector_address;
            need      <= req.need_contents;
            eidx      <= req.entry_index;
            mod_in    <= req.modified;
            imm_in    <= req.immediate;
            rem       <= '0;
            dcnt      <= '0;
            scnt      <= '0;
            wbn       <= '0;
            hit_found <= 1'b0;
            vic_found <= 1'b0;
            unique case (opcode_t'(req.opcode))
              OP_ACQ: state <= S_DIV;
              OP_REL: begin
                if (int'(req.entry_index) >= ENTRIES) begin
                  state <= S_BAD;
                end else begin
                  state <= S_REL_RD;
                end
              end
              OP_SYNC, OP_PURGE: state <= S_SW_RD;
            endcase
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          dsh  <= dsh << 4;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'd7) begin
            state <= S_TRK;
          end
        end
        S_TRK: begin
          trk   <= addr - ADDR_W'(rem);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_issue) begin
            scnt <= scnt + 1'b1;
          end
          if (pv) begin
            if (!hit_found && m.valid && t_dev == dev && t_trk == trk) begin
              hit_found <= 1'b1;
              hit_idx   <= raddr_q;
              hit_refs  <= m.refs;
              hit_rank  <= m.rank;
              hit_stale <= m.stale;
            end
            if (m.refs == '0 && (!vic_found || m.rank > vic_rank)) begin
              vic_found <= 1'b1;
              vic_idx   <= raddr_q;
              vic_rank  <= m.rank;
              vic_wb    <= m.valid && m.dirty;
              cap_dev   <= t_dev;
              cap_trk   <= t_trk;
            end
          end
          if (!rd_issue && !pv) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          scnt <= '0;
          if (hit_found) begin
            e       <= hit_idx;
            r       <= hit_rank;
            miss    <= 1'b0;
            wb_flag <= 1'b0;
            rd_flag <= need && hit_stale;
            if (hit_refs == REFS_W'(REFS_MAX)) begin
              busy_slot <= SLOT_W'(hit_idx);
              state     <= S_BUSY;
            end else begin
              state <= S_RANK;
            end
          end else if (!vic_found) begin
            busy_slot <= '0;
            state     <= S_BUSY;
          end else begin
            e       <= vic_idx;
            r       <= vic_rank;
            miss    <= 1'b1;
            wb_flag <= vic_wb;
            rd_flag <= need;
            state   <= S_RANK;
          end
        end
        S_RANK: begin
          if (rd_issue) begin
            scnt <= scnt + 1'b1;
          end
          if (!rd_issue && !pv) begin
            priority if (wb_flag) begin
              state <= S_EMIT_WB;
            end else if (rd_flag) begin
              state <= S_EMIT_RD;
            end else begin
              state <= S_EMIT_ACQ;
            end
          end
        end
        S_BUSY: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_BUSY, busy_slot, dev, trk, rem, 1'b1);
            state   <= S_IDLE;
          end
        end
        S_EMIT_WB: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_WB, SLOT_W'(e), cap_dev, cap_trk, '0, 1'b0);
            state   <= rd_flag ? S_EMIT_RD : S_EMIT_ACQ;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_RD, SLOT_W'(e), dev, trk, '0, 1'b0);
            state   <= S_EMIT_ACQ;
          end
        end
        S_EMIT_ACQ: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_ACQ, SLOT_W'(e), dev, trk, rem, 1'b1);
            state   <= S_IDLE;
          end
        end
        S_REL_RD: begin
          state <= S_REL_CHK;
        end
        S_REL_CHK: begin
          cap_dev <= t_dev;
          cap_trk <= t_trk;
          if (!rel_ok) begin
            state <= S_BAD;
          end else if ((m.imm | imm_in) && (m.dirty | mod_in)) begin
            state <= S_REL_WB;
          end else begin
            state <= S_REL_OUT;
          end
        end
        S_REL_WB: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_WB, eidx, cap_dev, cap_trk, '0, 1'b0);
            state   <= S_REL_OUT;
          end
        end
        S_REL_OUT: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_REL, eidx, cap_dev, cap_trk, '0, 1'b1);
            state   <= S_IDLE;
          end
        end
        S_BAD: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_BAD, eidx, '0, '0, '0, 1'b1);
            state   <= S_IDLE;
          end
        end
        S_SW_RD: begin
          if (scnt == CNT_W'(ENTRIES)) begin
            state <= S_DONE;
          end else begin
            state <= S_SW_CHK;
          end
        end
        S_SW_CHK: begin
          cap_dev <= t_dev;
          cap_trk <= t_trk;
          priority if (!sw_visit) begin
            scnt  <= scnt + 1'b1;
            state <= S_SW_RD;
          end else if (sw_stop) begin
            state <= S_DONE;
          end else if (m.dirty) begin
            state <= S_SW_WB;
          end else begin
            scnt  <= scnt + 1'b1;
            state <= S_SW_RD;
          end
        end
        S_SW_WB: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_WB, SLOT_W'(scnt), cap_dev, cap_trk, '0, 1'b0);
            wbn     <= wbn + 1'b1;
            scnt    <= scnt + 1'b1;
            state   <= S_SW_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            o_q     <= mk_rsp(K_DONE, '0, '0, '0, '0, 1'b1);
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TBCM_ASSERT(a_accept_leaves_idle, req.valid && req.ready |=> state != S_IDLE)
  `TBCM_NEVER(a_wb_cap, wbn > 6'(MAX_WB))
  `TBCM_ASSERT(a_meta_write_state, m_we |-> (state == S_RANK || state == S_REL_CHK || state == S_SW_CHK))
endmodule

/* verif/track_buffer_cache_manager_core_tb.sv */
// Self-checking testbench for the track buffer cache manager core with a built-in tag model.
module track_buffer_cache_manager_core_tb;
  import tbcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ENTRIES_DEF;
  localparam int IDLE_PCT = 17;
  localparam int SETTLE = 4 * NSLOT + 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    opcode_t           op;
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] sector;
    logic              need;
    logic [SLOT_W-1:0] idx;
    logic              mod;
    logic              imm;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [SPT_W-1:0] wr_data = '0;

  tbcm_req_if req ();
  tbcm_rsp_if rsp ();

  track_buffer_cache_manager_core u_top (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data), .req(req), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  request_t pending[$];
  rsp_t     awaited[$];
  logic     calm = 1'b0;
  logic     req_took = 1'b0;
  int       mismatches = 0;
  int       stall_cycles = 0;

  // Tag state of the cache as the requests see it.
  logic [SPT_W-1:0]  track_len;
  logic              tag_valid [NSLOT];
  logic [DEV_W-1:0]  tag_dev   [NSLOT];
  logic [ADDR_W-1:0] tag_track [NSLOT];
  int                tag_refs  [NSLOT];
  logic              tag_dirty [NSLOT];
  logic              tag_imm   [NSLOT];
  logic              tag_stale [NSLOT];
  int                tag_rank  [NSLOT];

  function automatic void add_result(kind_t k, int s, logic [DEV_W-1:0] d,
                                     logic [ADDR_W-1:0] t, logic [OFF_W-1:0] o, logic l);
    rsp_t r;
    r.kind = k;
    r.slot = s[SLOT_W-1:0];
    r.device_out = d;
    r.track_address = t;
    r.sector_offset = o;
    r.last = l;
    awaited.push_back(r);
  endfunction

  function automatic void clear_tags();
    track_len = SPT_W'(SPT_RESET);
    for (int i = 0; i < NSLOT; i++) begin
      tag_valid[i] = 1'b0; tag_dev[i] = '0; tag_track[i] = '0; tag_refs[i] = 0;
      tag_dirty[i] = 1'b0; tag_imm[i] = 1'b0; tag_stale[i] = 1'b0; tag_rank[i] = i;
    end
  endfunction

  function automatic void acquire_tags(request_t it);
    int len;
    int hit;
    int best;
    int n;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] trk;
    len = (track_len == 0) ? 1 : (track_len > SPT_MAX ? SPT_MAX : int'(track_len));
    off = it.sector % len;
    trk = it.sector - off;
    hit = -1;
    best = -1;
    n = 0;
    for (int i = 0; i < NSLOT; i++)
      if (hit < 0 && tag_valid[i] && tag_dev[i] == it.dev && tag_track[i] == trk) hit = i;
    if (hit >= 0) begin
      if (tag_refs[hit] >= REFS_MAX) begin
        add_result(K_BUSY, hit, it.dev, trk, off[OFF_W-1:0], 1'b1);
        return;
      end
    end else begin
      for (int i = 0; i < NSLOT; i++)
        if (tag_refs[i] == 0 && (best < 0 || tag_rank[i] > tag_rank[best])) best = i;
      if (best < 0) begin
        add_result(K_BUSY, 0, it.dev, trk, off[OFF_W-1:0], 1'b1);
        return;
      end
      hit = best;
      if (tag_valid[hit] && tag_dirty[hit])
        add_result(K_WB, hit, tag_dev[hit], tag_track[hit], '0, 1'b0);
      tag_valid[hit] = 1'b1; tag_dev[hit] = it.dev; tag_track[hit] = trk;
      tag_dirty[hit] = 1'b0; tag_imm[hit] = 1'b0; tag_stale[hit] = 1'b1;
    end
    for (int i = 0; i < NSLOT; i++)
      if (tag_rank[i] < tag_rank[hit]) tag_rank[i]++;
    tag_rank[hit] = 0;
    if (it.need && tag_stale[hit]) begin
      add_result(K_RD, hit, it.dev, trk, '0, 1'b0);
      tag_stale[hit] = 1'b0;
    end
    tag_refs[hit]++;
    add_result(K_ACQ, hit, it.dev, trk, off[OFF_W-1:0], 1'b1);
  endfunction

  function automatic void release_tags(request_t it);
    int e;
    e = it.idx;
    if (e >= NSLOT || !tag_valid[e] || tag_refs[e] == 0) begin
      add_result(K_BAD, e, '0, '0, '0, 1'b1);
      return;
    end
    tag_refs[e]--;
    tag_dirty[e] |= it.mod;
    tag_imm[e] |= it.imm;
    if (tag_imm[e]) begin
      if (tag_dirty[e]) add_result(K_WB, e, tag_dev[e], tag_track[e], '0, 1'b0);
      tag_dirty[e] = 1'b0;
      tag_imm[e] = 1'b0;
    end
    add_result(K_REL, e, tag_dev[e], tag_track[e], '0, 1'b1);
  endfunction

  function automatic void sweep_tags(request_t it);
    int n;
    logic purge;
    n = 0;
    purge = (it.op == OP_PURGE);
    for (int i = 0; i < NSLOT; i++) begin
      if (!tag_valid[i]) continue;
      if (purge && tag_dev[i] != it.dev) continue;
      if (!purge && !tag_dirty[i]) continue;
      if (tag_dirty[i]) begin
        if (n >= MAX_WB) break;
        add_result(K_WB, i, tag_dev[i], tag_track[i], '0, 1'b0);
        n++;
      end
      tag_dirty[i] = 1'b0;
      tag_imm[i] = 1'b0;
      if (purge) begin
        if (tag_refs[i] == 0) begin
          tag_valid[i] = 1'b0;
          tag_stale[i] = 1'b0;
        end else begin
          tag_stale[i] = 1'b1;
        end
      end
    end
    add_result(K_DONE, 0, '0, '0, '0, 1'b1);
  endfunction

  // Requests are modeled in queue order, which is the order the block accepts them.
  function automatic void send(request_t it);
    case (it.op)
      OP_ACQ:  acquire_tags(it);
      OP_REL:  release_tags(it);
      default: sweep_tags(it);
    endcase
    pending.push_back(it);
  endfunction

  function automatic request_t blank(opcode_t op);
    request_t it;
    it.op = op;
    it.dev = DEV_W'($urandom);
    it.sector = $urandom;
    it.need = 1'($urandom_range(1));
    it.idx = SLOT_W'($urandom);
    it.mod = 1'($urandom_range(1));
    it.imm = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic void acquire(logic [DEV_W-1:0] d, logic [ADDR_W-1:0] s, logic nc);
    request_t it;
    it = blank(OP_ACQ);
    it.dev = d;
    it.sector = s;
    it.need = nc;
    send(it);
  endfunction

  // Releases a referenced entry with a chance of good_pct percent; otherwise any index.
  function automatic void release_some(int good_pct, logic m, logic im);
    request_t it;
    int held[$];
    it = blank(OP_REL);
    it.mod = m;
    it.imm = im;
    for (int i = 0; i < NSLOT; i++) if (tag_valid[i] && tag_refs[i] > 0) held.push_back(i);
    if (held.size() > 0 && $urandom_range(99) < good_pct)
      it.idx = SLOT_W'(held[$urandom_range(held.size() - 1)]);
    send(it);
  endfunction

  function automatic void sweep(opcode_t op, logic [DEV_W-1:0] d);
    request_t it;
    it = blank(op);
    it.dev = d;
    send(it);
  endfunction

  function automatic void random_request();
    int pick;
    logic [DEV_W-1:0] d;
    logic [ADDR_W-1:0] s;
    pick = $urandom_range(99);
    d = ($urandom_range(9) == 0) ? DEV_W'($urandom) : DEV_W'($urandom_range(3));
    if ($urandom_range(9) == 0) s = $urandom;
    else s = ADDR_W'($urandom_range(40) * 5 + $urandom_range(70));
    if (pick < 50) acquire(d, s, 1'($urandom_range(1)));
    else if (pick < 85) release_some(85, 1'($urandom_range(1)), 1'($urandom_range(1)));
    else if (pick < 92) sweep(OP_SYNC, d);
    else sweep(OP_PURGE, d);
  endfunction

  task automatic drain_and_write(logic [SPT_W-1:0] value);
    while (pending.size() > 0 || awaited.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_data <= value;
    @(negedge clk);
    wr_en <= 1'b0;
    track_len = value;
  endtask

  // Request driver.
  always @(posedge clk) req_took <= req.valid && req.ready;

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_took) begin
      req.valid <= 1'b1;
    end else if (pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
      req.valid <= 1'b1;
      req.opcode <= pending[0].op;
      req.device_id <= pending[0].dev;
      req.sector_address <= pending[0].sector;
      req.need_contents <= pending[0].need;
      req.entry_index <= pending[0].idx;
      req.modified <= pending[0].mod;
      req.immediate <= pending[0].imm;
      void'(pending.pop_front());
    end else begin
      req.valid <= 1'b0;
    end
  end

  always @(negedge clk) rsp.ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);

  // Result monitor.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.kind = kind_t'(rsp.kind);
      got.slot = rsp.slot;
      got.device_out = rsp.device_out;
      got.track_address = rsp.track_address;
      got.sector_offset = rsp.sector_offset;
      got.last = rsp.last;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [DEV_W-1:0] d;
    req.valid = 1'b0;
    req.opcode = OP_ACQ;
    req.device_id = '0;
    req.sector_address = '0;
    req.need_contents = 1'b0;
    req.entry_index = '0;
    req.modified = 1'b0;
    req.immediate = 1'b0;
    rsp.ready = 1'b0;
    clear_tags();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sweep(OP_SYNC, 8'd0);
    acquire(8'd0, 32'd0, 1'b1);
    acquire(8'd255, 32'hFFFF_FFFF, 1'b0);
    acquire(8'd255, 32'hFFFF_FFFF, 1'b1);
    acquire(8'd0, 32'd17, 1'b0);
    acquire(8'd170, 32'h5555_5555, 1'b1);
    release_some(100, 1'b1, 1'b0);
    release_some(100, 1'b1, 1'b1);
    release_some(100, 1'b0, 1'b1);
    release_some(100, 1'b1, 1'b0);
    release_some(100, 1'b0, 1'b0);
    release_some(0, 1'b0, 1'b0);
    begin
      request_t it;
      it = blank(OP_REL);
      it.idx = 5'd31;
      send(it);
    end
    acquire(8'd0, 32'd18, 1'b1);
    release_some(100, 1'b1, 1'b0);
    sweep(OP_SYNC, 8'd0);
    acquire(8'd255, 32'hFFFF_FFFF, 1'b1);
    sweep(OP_PURGE, 8'd255);
    acquire(8'd255, 32'hFFFF_FFF0, 1'b1);
    sweep(OP_PURGE, 8'd0);
    for (int i = 0; i < 15; i++) random_request();

    drain_and_write(7'd1);
    for (int i = 0; i < 64; i++) acquire(8'd9, 32'd5, 1'($urandom_range(1)));
    while (tag_valid[0] || 1) begin
      int held;
      held = -1;
      for (int i = 0; i < NSLOT; i++) if (tag_valid[i] && tag_refs[i] > 0) held = i;
      if (held < 0) break;
      release_some(100, 1'($urandom_range(1)), $urandom_range(3) == 0);
    end
    for (int i = 0; i < 15; i++) random_request();

    drain_and_write(7'd64);
    calm = 1'b1;
    d = DEV_W'($urandom);
    for (int i = 0; i < 35; i++) acquire(d, ADDR_W'(i * 64 + $urandom_range(63)), 1'b1);
    for (int i = 0; i < 15; i++) random_request();
    while (pending.size() > 0) @(posedge clk);
    calm = 1'b0;
    for (int i = 0; i < 40; i++)
      release_some(100, 1'($urandom_range(1)), 1'($urandom_range(1)));

    drain_and_write(7'd0);
    for (int i = 0; i < 15; i++) random_request();
    drain_and_write(7'd127);
    for (int i = 0; i < 15; i++) random_request();
    drain_and_write(7'd7);
    for (int i = 0; i < 10; i++) random_request();
    sweep(OP_SYNC, 8'd0);

    while (pending.size() > 0 || awaited.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* track_buffer_cache_manager_core.f */
+incdir+hw/rtl
hw/rtl/tbcm_pkg.sv
hw/rtl/tbcm_req_if.sv
hw/rtl/tbcm_rsp_if.sv
hw/rtl/tbcm_ram.sv
hw/rtl/track_buffer_cache_manager_core.sv
verif/track_buffer_cache_manager_core_tb.sv
